### hw/rtl/slaw_pkg.sv
// slaw_pkg: shared constants, rounding and saturation helpers, and the sine and
// tanh table builders for the stereo lfo auto-pan block
// no dependencies
package slaw_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int TAB_N           = 1 << TABLE_ADDR_BITS;
  localparam int ROM_IDX_W       = TABLE_ADDR_BITS + 1;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // register indexes of the write port
  localparam logic [2:0] REG_PRESET     = 3'd0;
  localparam logic [2:0] REG_AMOUNT     = 3'd1;
  localparam logic [2:0] REG_INCREMENT  = 3'd2;
  localparam logic [2:0] REG_AMT_STEPS  = 3'd3;
  localparam logic [2:0] REG_RATE_STEPS = 3'd4;

  // preset codes
  localparam logic [1:0] PRESET_ORBIT = 2'd0;
  localparam logic [1:0] PRESET_PULSE = 2'd1;
  localparam logic [1:0] PRESET_WIDE  = 2'd2;
  localparam logic [1:0] PRESET_DRIFT = 2'd3;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] PHASE_MASK   = ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);

  // fixed factors, 0.85 and 0.65 in Q0.16, sqrt2 in Q2.30
  localparam logic signed [MUL_W-1:0] WIDE_FACTOR = 33'sd55706;
  localparam logic signed [MUL_W-1:0] PULSE_SIDE  = 33'sd42598;
  localparam logic signed [MUL_W-1:0] SQRT2_Q30   = 33'sd1518500250;

  typedef logic [23:0] rom_t [0:TAB_N];

  // pan depth per preset, Q0.16
  function automatic logic signed [MUL_W-1:0] pan_depth(input logic [1:0] p);
    case (p)
      PRESET_ORBIT: return 33'sd13369;
      PRESET_PULSE: return 33'sd9123;
      PRESET_WIDE:  return 33'sd21234;
      default:      return 33'sd8651;
    endcase
  endfunction

  // side depth per preset, Q0.16
  function automatic logic signed [MUL_W-1:0] side_depth(input logic [1:0] p);
    case (p)
      PRESET_ORBIT: return 33'sd11534;
      PRESET_PULSE: return 33'sd7864;
      PRESET_WIDE:  return 33'sd15204;
      default:      return 33'sd5767;
    endcase
  endfunction

  // round to nearest with ties away from zero, then shift right by s
  function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] v,
                                                   input logic [4:0] s);
    logic signed [PROD_W-1:0] h;
    logic signed [PROD_W-1:0] t;
    h = '0;
    h[s - 5'd1] = 1'b1;
    t = '0;
    t[0] = v[PROD_W-1];
    t = v + h - t;
    return t >>> s;
  endfunction

  // clamp to the signed sample range
  function automatic logic [SAMPLE_BITS-1:0] sat(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = '0;
    hi[SAMPLE_BITS-2:0] = '1;
    lo = ~hi;
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

  // series divisors of the sine polynomial
  function automatic longint unsigned sine_div(input int k);
    case (k)
      0:       return 64'd110;
      1:       return 64'd72;
      2:       return 64'd42;
      3:       return 64'd20;
      default: return 64'd6;
    endcase
  endfunction

  // unsigned quotient by shift and subtract, only used while the tables are built
  function automatic longint unsigned cdiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    logic [64:0]     r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // quarter-wave sine, Q1.23, built at elaboration
  function automatic rom_t build_sine_rom();
    rom_t r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    for (int i = 0; i <= TAB_N; i++) begin
      x  = (64'(i) * 64'd1686629713) >> TABLE_ADDR_BITS;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int k = 0; k < 5; k++) begin
        t = (64'd1 << 30) - cdiv((x2 * t) >> 30, sine_div(k));
      end
      s = (x * t) >> 30;
      s = (s + 64'd64) >> 7;
      if (s > (64'd1 << 23)) s = 64'd1 << 23;
      r[i] = s[23:0];
    end
    return r;
  endfunction

  // tanh(2.2*u), Q1.23, built at elaboration
  function automatic rom_t build_tanh_rom();
    rom_t r;
    longint unsigned z;
    longint unsigned w;
    longint unsigned term;
    longint unsigned e;
    longint unsigned v;
    for (int i = 0; i <= TAB_N; i++) begin
      z    = (64'(i) * 64'd73819750) >> TABLE_ADDR_BITS;
      w    = z >> 3;
      term = 64'd1 << 24;
      e    = 64'd1 << 24;
      for (int k = 1; k <= 12; k++) begin
        term = cdiv(term * w, 64'(k) << 24);
        e    = e + term;
      end
      for (int k = 0; k < 3; k++) begin
        e = (e * e + (64'd1 << 23)) >> 24;
      end
      v = cdiv(((e - (64'd1 << 24)) << 23) + ((e + (64'd1 << 24)) >> 1),
               e + (64'd1 << 24));
      r[i] = v[23:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/stereo_lfo_autopan_width.sv
// stereo_lfo_autopan_width: lfo auto-pan with mid/side width modulation
// depends on slaw_pkg (constants, rounding, table builders)

// One stereo request in, one processed pair out. After a request is taken the
// block runs 15 sequencer steps through a single shared 33x33 signed multiplier
// and one registered sine table port (plus a tanh table port), so out_valid is
// set when the last step finishes and the input is stalled until then; no new
// request is taken before the last one is through. The finished pair sits in an
// output register, so the next request can be taken while it waits. Writing
// amount_target or increment_target starts a bit-serial slope division (one
// start step, then 32 quotient steps; one per target, run in turn); input
// requests are stalled until it completes.
// The write port has no wait state and must only be used while no request is
// in flight.
module stereo_lfo_autopan_width (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [slaw_pkg::SAMPLE_BITS-1:0] left_in,
  input  logic signed [slaw_pkg::SAMPLE_BITS-1:0] right_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [slaw_pkg::SAMPLE_BITS-1:0] left_out,
  output logic signed [slaw_pkg::SAMPLE_BITS-1:0] right_out,
  input  logic                                  wr_en,
  input  logic [2:0]                            wr_index,
  input  logic [30:0]                           wr_data
);

  localparam int SB = slaw_pkg::SAMPLE_BITS;
  localparam int MW = slaw_pkg::MUL_W;
  localparam int PW = slaw_pkg::PROD_W;
  localparam int TA = slaw_pkg::TABLE_ADDR_BITS;
  localparam int RW = slaw_pkg::ROM_IDX_W;

  localparam slaw_pkg::rom_t SINE_ROM = slaw_pkg::build_sine_rom();
  localparam slaw_pkg::rom_t TANH_ROM = slaw_pkg::build_tanh_rom();

  // sequencer state codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PB   = 4'd1;
  localparam logic [3:0] S_L    = 4'd2;
  localparam logic [3:0] S_T    = 4'd3;
  localparam logic [3:0] S_S    = 4'd4;
  localparam logic [3:0] S_S2   = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_M2   = 4'd7;
  localparam logic [3:0] S_M3   = 4'd8;
  localparam logic [3:0] S_M4   = 4'd9;
  localparam logic [3:0] S_G1   = 4'd10;
  localparam logic [3:0] S_G2   = 4'd11;
  localparam logic [3:0] S_G3   = 4'd12;
  localparam logic [3:0] S_G4   = 4'd13;
  localparam logic [3:0] S_O1   = 4'd14;
  localparam logic [3:0] S_O2   = 4'd15;

  // configuration
  logic [1:0]  motion_preset;
  logic [15:0] amount_target;
  logic [30:0] increment_target;
  logic [15:0] amount_ramp_steps;
  logic [15:0] rate_ramp_steps;

  // lfo and ramp state
  logic [31:0] lfo_phase;
  logic [31:0] amount_value;
  logic [31:0] amount_slope;
  logic [15:0] amount_left;
  logic [31:0] increment_value;
  logic [31:0] increment_slope;
  logic [15:0] increment_left;

  // slope divider
  logic              pend_amt;
  logic              pend_inc;
  logic signed [32:0] num_amt;
  logic signed [32:0] num_inc;
  logic [15:0]       den_amt;
  logic [15:0]       den_inc;
  logic              div_busy;
  logic              div_sel;
  logic              div_neg;
  logic [4:0]        div_cnt;
  logic [15:0]       div_rem;
  logic [31:0]       div_q;
  logic [15:0]       div_den;
  logic [16:0]       div_trial;
  logic              div_ge;
  logic [15:0]       div_rem_next;
  logic [31:0]       div_quo;
  logic [31:0]       div_slope;
  logic signed [32:0] div_num;
  logic [32:0]       div_mag;

  // item datapath
  logic [3:0]            state;
  logic signed [SB:0]    samp_mid;
  logic signed [SB:0]    samp_side;
  logic [31:0]           xa;
  logic signed [24:0]    lfo;
  logic signed [24:0]    side;
  logic [31:0]           md_s;
  logic [31:0]           md_p;
  logic [31:0]           scale;
  logic [31:0]           ang;
  logic signed [26:0]    pl;
  logic signed [26:0]    pr;
  logic signed [24:0]    gl;
  logic signed [24:0]    gr;
  logic [SB-1:0]         res_left;
  logic signed [PW-1:0]  prod;
  logic [23:0]           sine_q;
  logic                  sine_neg;
  logic [23:0]           tanh_q;
  logic                  tanh_neg;

  logic [31:0]           a_phase;
  logic [16:0]           mot;
  logic [32:0]           mot_sum;
  logic signed [24:0]    sin_val;
  logic signed [24:0]    tanh_val;
  logic [31:0]           sine_addr;
  logic [TA-1:0]         sine_off;
  logic [RW-1:0]         sine_idx;
  logic [23:0]           sin_mag;
  logic [RW-1:0]         tanh_idx;
  logic signed [MW-1:0]  mul_a;
  logic signed [MW-1:0]  mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [PW-1:0]  addend;
  logic [4:0]            rsh;
  logic signed [PW-1:0]  rnd_a;
  logic signed [PW-1:0]  rnd_b;
  logic                  accept;
  logic                  finish;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || pend_amt || pend_inc || div_busy;
  assign finish   = (state == S_O2) && (!out_valid || !out_stall);

  assign a_phase = lfo_phase & slaw_pkg::PHASE_MASK;
  assign mot_sum = {1'b0, amount_value} + 33'd32768;
  assign mot     = mot_sum[32:16];

  // signed values of the registered table reads
  assign sin_val  = sine_neg ? -$signed({1'b0, sine_q}) : $signed({1'b0, sine_q});
  assign tanh_val = tanh_neg ? -$signed({1'b0, tanh_q}) : $signed({1'b0, tanh_q});

  // sine table address per step
  always_comb begin
    case (state)
      S_L:     sine_addr = (motion_preset == slaw_pkg::PRESET_WIDE) ? prod[47:16] : a_phase;
      S_T:     sine_addr = (motion_preset == slaw_pkg::PRESET_PULSE) ? {xa[30:0], 1'b0}
                                                                     : xa + slaw_pkg::QUARTER_TURN;
      S_G1:    sine_addr = ang + slaw_pkg::QUARTER_TURN;
      default: sine_addr = ang;
    endcase
  end

  // quarter-wave folding
  assign sine_off = sine_addr[29:30-TA];
  assign sine_idx = sine_addr[30] ? RW'(slaw_pkg::TAB_N) - {1'b0, sine_off} : {1'b0, sine_off};

  // tanh address from the magnitude of the raw lfo sine
  assign sin_mag  = sin_val[24] ? 24'(-sin_val) : 24'(sin_val);
  assign tanh_idx = (sin_mag[23:23-TA] > RW'(slaw_pkg::TAB_N)) ? RW'(slaw_pkg::TAB_N)
                                                               : sin_mag[23:23-TA];

  // shared multiplier operand selection
  always_comb begin
    case (state)
      S_PB: begin
        mul_a = $signed({1'b0, a_phase});
        mul_b = slaw_pkg::WIDE_FACTOR;
      end
      S_S: begin
        mul_a = MW'(sin_val);
        mul_b = slaw_pkg::PULSE_SIDE;
      end
      S_S2: begin
        mul_a = $signed({16'd0, mot});
        mul_b = slaw_pkg::side_depth(motion_preset);
      end
      S_M1: begin
        mul_a = $signed({16'd0, mot});
        mul_b = slaw_pkg::pan_depth(motion_preset);
      end
      S_M2: begin
        mul_a = MW'(side);
        mul_b = $signed({1'b0, md_s});
      end
      S_M3: begin
        mul_a = MW'(lfo);
        mul_b = $signed({1'b0, md_p});
      end
      S_M4: begin
        mul_a = MW'(samp_side);
        mul_b = $signed({1'b0, scale});
      end
      S_G2, S_G3: begin
        mul_a = MW'(sin_val);
        mul_b = slaw_pkg::SQRT2_Q30;
      end
      S_G4: begin
        mul_a = MW'(pl);
        mul_b = MW'(gl);
      end
      default: begin
        mul_a = MW'(pr);
        mul_b = MW'(gr);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounding unit on the previous product
  always_comb begin
    case (state)
      S_S2:       rsh = 5'd16;
      S_M3:       rsh = 5'd25;
      S_M4:       rsh = 5'd26;
      S_G1:       rsh = 5'd31;
      S_G3, S_G4: rsh = 5'd30;
      default:    rsh = 5'd23;
    endcase
  end

  assign addend = (state == S_G1) ? (PW'(samp_mid) <<< 30) : '0;
  assign rnd_a  = slaw_pkg::rnd(addend + prod, rsh);
  assign rnd_b  = slaw_pkg::rnd(addend - prod, 5'd31);

  // bit-serial restoring divider step
  assign div_trial    = {div_rem, div_q[31]};
  assign div_ge       = div_trial >= {1'b0, div_den};
  assign div_rem_next = div_ge ? 16'(div_trial - {1'b0, div_den}) : div_trial[15:0];
  assign div_quo      = {div_q[30:0], div_ge};
  assign div_slope    = div_neg ? -div_quo : div_quo;
  assign div_num      = pend_amt ? num_amt : num_inc;
  assign div_mag      = div_num[32] ? 33'(-div_num) : 33'(div_num);

  // configuration, ramps and slope division
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_preset     <= slaw_pkg::PRESET_ORBIT;
      amount_target     <= '0;
      increment_target  <= '0;
      amount_ramp_steps <= 16'd3528;
      rate_ramp_steps   <= 16'd8820;
      amount_value      <= '0;
      amount_slope      <= '0;
      amount_left       <= '0;
      increment_value   <= '0;
      increment_slope   <= '0;
      increment_left    <= '0;
      pend_amt          <= 1'b0;
      pend_inc          <= 1'b0;
      div_busy          <= 1'b0;
      div_sel           <= 1'b0;
    end else begin
      // divider runs or picks up a pending slope
      if (div_busy) begin
        div_rem <= div_rem_next;
        div_q   <= div_quo;
        div_cnt <= div_cnt + 5'd1;
        if (div_cnt == 5'd31) begin
          div_busy <= 1'b0;
          if (div_sel) increment_slope <= div_slope;
          else amount_slope <= div_slope;
        end
      end else if (pend_amt || pend_inc) begin
        div_busy <= 1'b1;
        div_sel  <= !pend_amt;
        div_neg  <= div_num[32];
        div_q    <= div_mag[31:0];
        div_rem  <= '0;
        div_cnt  <= '0;
        div_den  <= pend_amt ? den_amt : den_inc;
        if (pend_amt) pend_amt <= 1'b0;
        else pend_inc <= 1'b0;
      end

      // one ramp step per accepted request
      if (accept) begin
        if (amount_left == '0) begin
          amount_value <= {amount_target, amount_target};
        end else begin
          amount_left <= amount_left - 16'd1;
          if (amount_left != 16'd1) amount_value <= amount_value + amount_slope;
          else amount_value <= {amount_target, amount_target};
        end
        if (increment_left == '0) begin
          increment_value <= {1'b0, increment_target};
        end else begin
          increment_left <= increment_left - 16'd1;
          if (increment_left != 16'd1) increment_value <= increment_value + increment_slope;
          else increment_value <= {1'b0, increment_target};
        end
      end

      // register writes, target writes restart their ramp
      if (wr_en) begin
        case (wr_index)
          slaw_pkg::REG_PRESET: motion_preset <= wr_data[1:0];
          slaw_pkg::REG_AMOUNT: begin
            amount_target <= wr_data[15:0];
            if (div_busy && !div_sel) div_busy <= 1'b0;
            if (amount_ramp_steps == '0) begin
              amount_value <= {wr_data[15:0], wr_data[15:0]};
              amount_slope <= '0;
              amount_left  <= '0;
              pend_amt     <= 1'b0;
            end else begin
              amount_left <= amount_ramp_steps;
              num_amt     <= $signed({1'b0, wr_data[15:0], wr_data[15:0]})
                             - $signed({1'b0, amount_value});
              den_amt     <= amount_ramp_steps;
              pend_amt    <= 1'b1;
            end
          end
          slaw_pkg::REG_INCREMENT: begin
            increment_target <= wr_data;
            if (div_busy && div_sel) div_busy <= 1'b0;
            if (rate_ramp_steps == '0) begin
              increment_value <= {1'b0, wr_data};
              increment_slope <= '0;
              increment_left  <= '0;
              pend_inc        <= 1'b0;
            end else begin
              increment_left <= rate_ramp_steps;
              num_inc        <= $signed({2'b0, wr_data}) - $signed({1'b0, increment_value});
              den_inc        <= rate_ramp_steps;
              pend_inc       <= 1'b1;
            end
          end
          slaw_pkg::REG_AMT_STEPS:  amount_ramp_steps <= wr_data[15:0];
          slaw_pkg::REG_RATE_STEPS: rate_ramp_steps   <= wr_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // table reads, registered
  always_ff @(posedge clk) begin
    sine_q   <= SINE_ROM[sine_idx];
    sine_neg <= sine_addr[31];
    tanh_q   <= TANH_ROM[tanh_idx];
    tanh_neg <= sin_val[24];
    prod     <= mul_p;
  end

  // sequencer payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      samp_mid  <= (SB+1)'(left_in) + (SB+1)'(right_in);
      samp_side <= (SB+1)'(left_in) - (SB+1)'(right_in);
    end
    case (state)
      S_L: xa <= sine_addr;
      S_T: lfo <= sin_val;
      S_S: begin
        if (motion_preset == slaw_pkg::PRESET_PULSE) lfo <= tanh_val;
        side <= (motion_preset == slaw_pkg::PRESET_DRIFT) ? lfo : sin_val;
      end
      S_S2: if (motion_preset == slaw_pkg::PRESET_PULSE) side <= rnd_a[24:0];
      S_M1: md_s <= prod[31:0];
      S_M2: md_p <= prod[31:0];
      S_M3: scale <= 32'h4000_0000 + rnd_a[31:0];
      S_M4: ang <= 32'h2000_0000 + rnd_a[31:0];
      S_G1: begin
        pl <= rnd_a[26:0];
        pr <= rnd_b[26:0];
      end
      S_G3: gl <= rnd_a[24:0];
      S_G4: gr <= rnd_a[24:0];
      S_O1: res_left <= slaw_pkg::sat(rnd_a);
      default: ;
    endcase
    if (finish) begin
      left_out  <= res_left;
      right_out <= slaw_pkg::sat(rnd_a);
    end
  end

  // sequencer control, phase and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lfo_phase <= '0;
      out_valid <= 1'b0;
    end else begin
      if (finish) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (accept) state <= S_PB;
        S_O2: begin
          if (finish) begin
            lfo_phase <= lfo_phase + increment_value;
            state     <= S_IDLE;
          end
        end
        default: state <= state + 4'd1;
      endcase
    end
  end

endmodule

### hw/rtl/slaw_checker.sv
// slaw_checker: port-level checks for stereo_lfo_autopan_width, with its bind
// depends on slaw_pkg and the top level's ports only
module slaw_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [slaw_pkg::SAMPLE_BITS-1:0] left_out,
  input logic signed [slaw_pkg::SAMPLE_BITS-1:0] right_out
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("stalled result changed");

  // one request at a time: busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // a new result only appears at the end of a busy stretch
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind stereo_lfo_autopan_width slaw_checker u_slaw_checker (.*);

### sim/stereo_lfo_autopan_width_test.sv
// testbench for stereo_lfo_autopan_width: random and directed stereo pairs with a
// bit-exact predictor of the lfo auto-pan and width modulation
// depends on slaw_pkg and the stereo_lfo_autopan_width rtl
`timescale 1ns / 100ps

module stereo_lfo_autopan_width_test;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } pair_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [23:0] left_in;
  logic signed [23:0] right_in;
  logic out_valid;
  logic out_stall;
  logic signed [23:0] left_out;
  logic signed [23:0] right_out;
  logic wr_en;
  logic [2:0] wr_index;
  logic [30:0] wr_data;

  stereo_lfo_autopan_width dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .left_in(left_in), .right_in(right_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_out(left_out), .right_out(right_out),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  longint sine_q [0:slaw_pkg::TAB_N];
  longint tanh_q [0:slaw_pkg::TAB_N];
  logic [1:0] cur_preset;
  logic [31:0] amt_goal, inc_goal;
  logic [15:0] amt_len, inc_len;
  logic [31:0] lfo_acc, amt_val, amt_slope, inc_val, inc_slope;
  logic [15:0] amt_rem, inc_rem;

  pair_t expected_pairs[$];
  int fails;
  int pairs_sent;
  int pairs_checked;
  int hold_cycles;
  bit no_gaps;

  // round to nearest, ties away from zero
  function automatic longint round_shift(input longint v, input int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  // quarter-wave sine and tanh tables from integer series
  task automatic fill_tables();
    longint unsigned x, x2, t, s, z, w, term, e;
    longint unsigned dv [5];
    dv = '{110, 72, 42, 20, 6};
    for (int i = 0; i <= slaw_pkg::TAB_N; i++) begin
      x = (64'(i) * 64'd1686629713) / 64'(slaw_pkg::TAB_N);
      x2 = (x * x) >> 30;
      t = 64'd1 << 30;
      for (int k = 0; k < 5; k++) t = (64'd1 << 30) - ((x2 * t) >> 30) / dv[k];
      s = (x * t) >> 30;
      s = (s + 64) >> 7;
      if (s > (64'd1 << 23)) s = 64'd1 << 23;
      sine_q[i] = longint'(s);
      z = (64'(i) * 64'd73819750) / 64'(slaw_pkg::TAB_N);
      w = z >> 3;
      term = 64'd1 << 24;
      e = 64'd1 << 24;
      for (int k = 1; k <= 12; k++) begin
        term = (term * w) / (64'(k) << 24);
        e += term;
      end
      for (int k = 0; k < 3; k++) e = (e * e + (64'd1 << 23)) >> 24;
      tanh_q[i] = longint'((((e - (64'd1 << 24)) << 23) + ((e + (64'd1 << 24)) >> 1))
                           / (e + (64'd1 << 24)));
    end
  endtask

  function automatic longint sine_of(input logic [31:0] a);
    logic [9:0] idx;
    longint v;
    idx = a[29:20];
    v = a[30] ? sine_q[slaw_pkg::TAB_N - idx] : sine_q[idx];
    return a[31] ? -v : v;
  endfunction

  function automatic longint shaped_tanh(input longint s);
    longint m, idx;
    m = (s < 0) ? -s : s;
    idx = m >>> 13;
    if (idx > slaw_pkg::TAB_N) idx = slaw_pkg::TAB_N;
    return (s < 0) ? -tanh_q[idx] : tanh_q[idx];
  endfunction

  // glide restart on a target write
  task automatic glide_restart(inout logic [31:0] val, inout logic [31:0] slope,
                               inout logic [15:0] rem, input logic [31:0] goal,
                               input logic [15:0] len);
    if (len == 0) begin
      val = goal;
      slope = 0;
      rem = 0;
    end else begin
      rem = len;
      slope = 32'((longint'(goal) - longint'(val)) / longint'(len));
    end
  endtask

  task automatic glide_step(inout logic [31:0] val, input logic [31:0] slope,
                            inout logic [15:0] rem, input logic [31:0] goal);
    if (rem == 0) val = goal;
    else begin
      rem--;
      if (rem != 0) val = val + slope;
      else val = goal;
    end
  endtask

  task automatic apply_register(input logic [2:0] idx, input logic [30:0] data);
    case (idx)
      slaw_pkg::REG_PRESET: cur_preset = data[1:0];
      slaw_pkg::REG_AMOUNT: begin
        amt_goal = {16'd0, data[15:0]} * 32'd65537;
        glide_restart(amt_val, amt_slope, amt_rem, amt_goal, amt_len);
      end
      slaw_pkg::REG_INCREMENT: begin
        inc_goal = {1'b0, data};
        glide_restart(inc_val, inc_slope, inc_rem, inc_goal, inc_len);
      end
      slaw_pkg::REG_AMT_STEPS: amt_len = data[15:0];
      slaw_pkg::REG_RATE_STEPS: inc_len = data[15:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  // one processed pair from the predictor, advancing its state
  task automatic process_pair(input logic signed [23:0] l, input logic signed [23:0] r,
                              output pair_t res);
    longint mot, lfo, side, scale, ang, gl, gr, mid2, side2, pl, pr, pd, sd;
    logic [31:0] a, b;
    glide_step(amt_val, amt_slope, amt_rem, amt_goal);
    glide_step(inc_val, inc_slope, inc_rem, inc_goal);
    mot = (longint'(amt_val) + 32768) >>> 16;
    a = lfo_acc;
    case (cur_preset)
      slaw_pkg::PRESET_ORBIT: begin
        lfo = sine_of(a);
        side = sine_of(a + slaw_pkg::QUARTER_TURN);
        pd = 13369; sd = 11534;
      end
      slaw_pkg::PRESET_PULSE: begin
        lfo = shaped_tanh(sine_of(a));
        side = round_shift(sine_of(a << 1) * 42598, 16);
        pd = 9123; sd = 7864;
      end
      slaw_pkg::PRESET_WIDE: begin
        b = 32'((64'(a) * 64'd55706) >> 16);
        lfo = sine_of(b);
        side = sine_of(b + slaw_pkg::QUARTER_TURN);
        pd = 21234; sd = 15204;
      end
      default: begin
        lfo = sine_of(a);
        side = lfo;
        pd = 8651; sd = 5767;
      end
    endcase
    scale = (64'sd1 <<< 30) + round_shift(side * mot * sd, 25);
    ang = (64'sd1 <<< 29) + round_shift(lfo * mot * pd, 26);
    gl = round_shift(sine_of(32'(ang) + slaw_pkg::QUARTER_TURN) * 1518500250, 30);
    gr = round_shift(sine_of(32'(ang)) * 1518500250, 30);
    mid2 = longint'(l) + longint'(r);
    side2 = longint'(l) - longint'(r);
    pl = round_shift(mid2 * (64'sd1 <<< 30) + side2 * scale, 31);
    pr = round_shift(mid2 * (64'sd1 <<< 30) - side2 * scale, 31);
    res.left = clamp24(round_shift(pl * gl, 23));
    res.right = clamp24(round_shift(pr * gr, 23));
    lfo_acc = lfo_acc + inc_val;
  endtask

  // predict on every accepted request
  always @(posedge clk) begin
    pair_t p;
    if (!rst && in_valid && !in_stall) begin
      process_pair(left_in, right_in, p);
      expected_pairs.push_back(p);
      pairs_sent++;
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    pair_t p;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result left %0d right %0d", $time, left_out, right_out);
        fails++;
      end else begin
        p = expected_pairs.pop_front();
        if (left_out !== p.left) begin
          $display("%0t: left_out expected %0d actual %0d", $time, p.left, left_out);
          fails++;
        end
        if (right_out !== p.right) begin
          $display("%0t: right_out expected %0d actual %0d", $time, p.right, right_out);
          fails++;
        end
      end
      pairs_checked++;
    end
  end

  // receiver: random stall per result, or a long hold-off when asked
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else n = no_gaps ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !rst));
    end
  end

  // sender: random gap, then hold the request until taken
  task automatic send_pair(input logic signed [23:0] l, input logic signed [23:0] r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_in <= l;
    right_in <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_pair(24'($urandom), 24'($urandom));
  endtask

  // wait until the block is idle, then write a register
  task automatic write_reg(input logic [2:0] idx, input logic [30:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    apply_register(idx, data);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_pair(24'sd8388607, 24'sd8388607);
    send_pair(-24'sd8388608, -24'sd8388608);
    send_pair(24'sd8388607, -24'sd8388608);
    send_pair(-24'sd8388608, 24'sd8388607);
    send_pair(24'sd0, 24'sd0);
    send_pair(-24'sd1, 24'sd1);
  endtask

  // every preset at full amount, zero glide, fast rate, extreme samples
  task automatic test_presets();
    write_reg(slaw_pkg::REG_AMT_STEPS, 31'd0);
    write_reg(slaw_pkg::REG_RATE_STEPS, 31'd0);
    write_reg(slaw_pkg::REG_AMOUNT, 31'h7fff_ffff);
    write_reg(slaw_pkg::REG_INCREMENT, 31'h7fff_ffff);
    for (int p = 0; p < 4; p++) begin
      write_reg(slaw_pkg::REG_PRESET, {29'h1fff_ffff, 2'(p)});
      send_pair(24'sd8388607, -24'sd8388608);
      send_pair(-24'sd8388608, 24'sd8388607);
      send_pair(24'sd8388607, 24'sd8388607);
      send_random(3);
    end
    // unknown registers must leave everything as it is
    write_reg(3'd5, 31'd0);
    write_reg(3'd6, 31'h7fff_ffff);
    write_reg(3'd7, 31'd1);
    send_random(2);
  endtask

  // one-step glide and restarts with the same target
  task automatic test_glides();
    write_reg(slaw_pkg::REG_PRESET, 31'(slaw_pkg::PRESET_WIDE));
    write_reg(slaw_pkg::REG_AMT_STEPS, 31'd1);
    write_reg(slaw_pkg::REG_RATE_STEPS, 31'd1);
    write_reg(slaw_pkg::REG_AMOUNT, 31'd0);
    write_reg(slaw_pkg::REG_INCREMENT, 31'd12345);
    send_random(2);
    write_reg(slaw_pkg::REG_AMT_STEPS, 31'd7);
    write_reg(slaw_pkg::REG_RATE_STEPS, 31'd5);
    write_reg(slaw_pkg::REG_AMOUNT, 31'd65535);
    send_random(3);
    write_reg(slaw_pkg::REG_AMOUNT, 31'd65535);
    write_reg(slaw_pkg::REG_INCREMENT, 31'd12345);
    send_random(10);
  endtask

  // receiver holds off long so the block backs up into the input
  task automatic test_backpressure();
    hold_cycles = 300;
    no_gaps = 1'b1;
    send_random(12);
    no_gaps = 1'b0;
  endtask

  // random settings, several long phases, four of them without gaps
  task automatic test_random_phases();
    for (int ph = 0; ph < 20; ph++) begin
      write_reg(slaw_pkg::REG_PRESET, 31'($urandom));
      write_reg(slaw_pkg::REG_AMT_STEPS,
                (ph % 5 == 0) ? 31'd65535 : 31'($urandom_range(0, 60)));
      write_reg(slaw_pkg::REG_RATE_STEPS,
                (ph % 7 == 1) ? 31'd65535 : 31'($urandom_range(0, 60)));
      write_reg(slaw_pkg::REG_AMOUNT, (ph % 4 == 3) ? 31'd0 : 31'($urandom));
      write_reg(slaw_pkg::REG_INCREMENT, (ph % 6 == 2) ? 31'd0 : 31'($urandom));
      no_gaps = (ph % 5 == 4);
      send_random(65);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    fill_tables();
    cur_preset = slaw_pkg::PRESET_ORBIT;
    amt_goal = 0; inc_goal = 0;
    amt_len = 16'd3528; inc_len = 16'd8820;
    lfo_acc = 0; amt_val = 0; amt_slope = 0; amt_rem = 0;
    inc_val = 0; inc_slope = 0; inc_rem = 0;
    fails = 0; pairs_sent = 0; pairs_checked = 0;
    hold_cycles = 0; no_gaps = 1'b0;
    clk = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    left_in <= '0;
    right_in <= '0;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_presets();
    test_glides();
    test_backpressure();
    test_random_phases();

    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d stereo pairs, %0d results checked, all presets and glides",
             pairs_sent, pairs_checked);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fails);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #8ms;
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
hw/rtl/slaw_pkg.sv
hw/rtl/stereo_lfo_autopan_width.sv
hw/rtl/slaw_checker.sv
sim/stereo_lfo_autopan_width_test.sv
